/* src/irt_pkg.sv */
package irt_pkg;

  localparam int TIME_W   = 16;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 8;

  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [USED_W-1:0]   used_t;

  // closed interval, both ends inclusive
  typedef struct packed {
    time_t start;
    time_t finish;
  } interval_t;

  localparam status_t ST_ACCEPT  = 2'd0;
  localparam status_t ST_OVERLAP = 2'd1;
  localparam status_t ST_FULL    = 2'd2;

  function automatic logic overlaps(interval_t a, interval_t b);
    return (a.start <= b.finish) && (a.finish >= b.start);
  endfunction

endpackage

/* src/irt_req_if.sv */
interface irt_req_if;
  import irt_pkg::*;

  logic  valid;
  logic  ready;
  time_t new_start;
  time_t new_finish;

  modport source (output valid, output new_start, output new_finish, input ready);
  modport sink   (input valid, input new_start, input new_finish, output ready);
endinterface

/* src/irt_rsp_if.sv */
interface irt_rsp_if;
  import irt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  used_t   entries_used;

  modport source (output valid, output status, output entries_used, input ready);
  modport sink   (input valid, input status, input entries_used, output ready);
endinterface

/* src/irt_store.sv */
module irt_store #(
  parameter int CAPACITY = 128,
  parameter int AW       = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  irt_pkg::interval_t wr_data,
  input  irt_pkg::interval_t query,
  output logic               hit
);
  import irt_pkg::*;

  interval_t mem [CAPACITY];
  interval_t rd_data;
  logic      rd_valid;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // compare the returned entry against the held request
  assign hit = rd_valid && overlaps(query, rd_data);

endmodule

/* src/interval_reservation_table.sv */
// Interval reservation table: holds up to CAPACITY accepted closed intervals
// [start, finish] and admits a new request only if it overlaps none of them.
// Each request item yields exactly one result item: status 0 when the
// interval was stored, 1 when it overlaps a stored interval (checked first,
// so it wins even on a full table), 2 when it overlaps nothing but the table
// is full; entries_used is the count after the request, modulo 256. An
// inverted interval (start after finish) is tested with the same two
// comparisons and stored as given. The stored bounds sit in one single-port
// read, single-port write memory, scanned one entry per cycle. A request goes
// through these steps in order: acceptance, one read per stored entry, the
// return of the last read, and the decision with write back, which waits
// while the output register still holds an uncollected result; the result
// is offered on the cycle after the decision. Requests are handled one at a
// time; the result waits in an output register, so a new request can be
// taken while the previous result has not yet been collected. The request
// side is held off during reset. The table is empty after reset and needs
// no clearing pass: only entries below the count are read.
module interval_reservation_table #(
  parameter int CAPACITY = 128
) (
  input logic      clk,
  input logic      rst,
  irt_req_if.sink  req,
  irt_rsp_if.source rsp
);
  import irt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  interval_t     query;           // request under test
  logic [CW-1:0] count;           // stored entries
  logic [CW-1:0] scan_idx;        // next entry to read
  logic          hit_acc;         // any overlap seen so far
  logic          store_hit;

  logic          rd_en;
  logic          wr_en;
  logic          decide_fire;
  logic          final_hit;
  logic          is_full;
  status_t       status_next;
  logic [CW-1:0] count_next;
  logic [CW+USED_W-1:0] count_ext;

  logic    out_valid;
  status_t out_status;
  used_t   out_used;

  // request side is open whenever no request is in progress and reset is low
  assign req.ready = (state == S_IDLE) && !rst;

  // issue reads while entries remain
  assign rd_en = (state == S_SCAN) && (scan_idx < count);

  // the last read returns in the final scan cycle, so by the decide cycle
  // every compare has been folded into hit_acc
  assign final_hit = hit_acc;
  assign is_full   = (count == CW'(CAPACITY));

  // decide only once the output register can take the result
  assign decide_fire = (state == S_DECIDE) && (!out_valid || rsp.ready);

  always_comb begin
    status_next = ST_ACCEPT;
    count_next  = count;
    wr_en       = 1'b0;
    if (final_hit) begin
      status_next = ST_OVERLAP;
    end else if (is_full) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_ACCEPT;
      count_next  = count + CW'(1);
      wr_en       = decide_fire;
    end
  end

  assign count_ext = {{USED_W{1'b0}}, count_next};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!rd_en) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (decide_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      hit_acc   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (req.valid && req.ready) begin
        scan_idx <= '0;
        hit_acc  <= 1'b0;
      end else begin
        if (rd_en) begin
          scan_idx <= scan_idx + CW'(1);
        end
        if (store_hit) begin
          hit_acc <= 1'b1;
        end
      end

      if (decide_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      query.start  <= req.new_start;
      query.finish <= req.new_finish;
    end
    if (decide_fire) begin
      out_status <= status_next;
      out_used   <= count_ext[USED_W-1:0];
    end
  end

  irt_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[AW-1:0]),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (query),
    .query   (query),
    .hit     (store_hit)
  );

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.entries_used = out_used;

endmodule
